FILE: rtl/cht_pkg.sv
// shared types, constants and codes of the chained hash table engine
// no dependencies; every other file of the block imports it
package cht_pkg;

    // default geometry of the table
    localparam int BUCKETS_DEF = 11;
    localparam int WAYS_DEF    = 4;

    // field widths
    localparam int KEY_W   = 64;
    localparam int GRADE_W = 8;
    // sum of eight key bytes fits in 11 bits
    localparam int SUM_W   = 11;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GRADE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRADE = 1'b1;

    // reset values of the range bounds
    localparam logic [GRADE_W-1:0] MIN_GRADE_RST = 8'd80;
    localparam logic [GRADE_W-1:0] MAX_GRADE_RST = 8'd90;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_SCAN   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        RS_INSERTED = 3'd0,
        RS_UPDATED  = 3'd1,
        RS_REMOVED  = 3'd2,
        RS_FOUND    = 3'd3,
        RS_MISSING  = 3'd4,
        RS_FULL     = 3'd5,
        RS_MATCH    = 3'd6,
        RS_NONE     = 3'd7
    } res_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_FILL_WAIT,
        S_WALK_RD,
        S_WALK_CMP,
        S_HIT,
        S_MISS,
        S_SHIFT_WR,
        S_SCAN_FILL,
        S_SCAN_FWAIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_END
    } ctrl_state_t;

    typedef struct packed {
        action_t             action;
        logic [KEY_W-1:0]    student_key;
        logic [GRADE_W-1:0]  grade_value;
    } cmd_word_t;

    typedef struct packed {
        res_status_t         status;
        logic [KEY_W-1:0]    result_key;
        logic [GRADE_W-1:0]  result_grade;
        logic                last_result;
    } res_word_t;

    // one stored entry
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [GRADE_W-1:0]  grade;
    } ent_t;

endpackage

FILE: rtl/cht_bucket_hash.sv
// three stage bucket hash: byte sum, reciprocal multiply, remainder fix-up
// depends on cht_pkg
module cht_bucket_hash
    import cht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int BKT_W   = $clog2(BUCKETS_DEF)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [BKT_W-1:0] bucket
);

    localparam int RECIP_SH = 24;
    localparam int PROD_W   = SUM_W + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP  = RECIP_SH'((64'd1 << RECIP_SH) / BUCKETS);
    localparam logic [SUM_W-1:0]    BKT_C  = SUM_W'(BUCKETS);

    logic [2:0]        vld_reg;
    logic [SUM_W-1:0]  sum1_reg;
    logic [SUM_W-1:0]  sum2_reg;
    logic [SUM_W-1:0]  quo2_reg;
    logic [BKT_W-1:0]  bucket_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  rem_raw;
    logic [SUM_W-1:0]  rem_fix;

    // byte sum of the key
    always_comb
    begin
        sum_next = '0;
        for (int b = 0; b < 8; b++)
        begin
            sum_next = sum_next + SUM_W'(key[8*b +: 8]);
        end
    end

    // quotient estimate, low by at most one
    assign prod = PROD_W'(sum1_reg) * PROD_W'(RECIP);

    // remainder with one correction step
    always_comb
    begin
        rem_raw = sum2_reg - SUM_W'(quo2_reg * BKT_C);
        rem_fix = (rem_raw >= BKT_C) ? (rem_raw - BKT_C) : rem_raw;
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        sum1_reg   <= sum_next;
        sum2_reg   <= sum1_reg;
        quo2_reg   <= SUM_W'(prod >> RECIP_SH);
        bucket_reg <= BKT_W'(rem_fix);
    end

    assign done   = vld_reg[2];
    assign bucket = bucket_reg;

endmodule

FILE: rtl/cht_entry_ram.sv
// entry store: keys and grades, one write and one registered read a cycle
// depends on cht_pkg
module cht_entry_ram
    import cht_pkg::*;
#(
    parameter int DEPTH  = BUCKETS_DEF * WAYS_DEF,
    parameter int ADDR_W = $clog2(BUCKETS_DEF * WAYS_DEF)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output ent_t              rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  ent_t              wr_data
);

    ent_t mem [DEPTH];
    ent_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/cht_fill_store.sv
// per-bucket fill counts in a small memory, with a valid flag per bucket
// depends on cht_pkg; an unwritten bucket reads as empty
module cht_fill_store
    import cht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int BKT_W   = $clog2(BUCKETS_DEF),
    parameter int FILL_W  = $clog2(WAYS_DEF + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [BKT_W-1:0]  rd_addr,
    output logic [FILL_W-1:0] rd_fill,
    input  logic              wr_en,
    input  logic [BKT_W-1:0]  wr_addr,
    input  logic [FILL_W-1:0] wr_fill
);

    logic [FILL_W-1:0]  mem [BUCKETS];
    logic [BUCKETS-1:0] valid_reg;
    logic [FILL_W-1:0]  rd_mem_reg;
    logic               rd_vld_reg;

    // count memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_fill;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    // written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_fill = rd_vld_reg ? rd_mem_reg : '0;

endmodule

FILE: rtl/chained_hash_table_engine_core.sv
// Chained hash table engine, top level: one command word at a time. A key
// goes through the bucket hash, then the bucket's fill count is read, then
// each slot walked costs an entry memory read and a key compare; the result
// word is registered, and the engine waits while the result side stalls. A
// lookup, insert or remove walks slots until it finds its key or reaches the
// fill count (at most WAYS slots); a remove also moves each later entry of
// the bucket up one slot to close the gap. A range scan reads every bucket's
// fill count and every stored entry, one entry at a time over the read port
// of the entry memory.
// Bucket fill counts carry a valid flag per bucket, so the table is empty
// right after reset with no clearing pass. The user must write range bounds
// on the configuration port only while the engine is idle; the block itself
// does not enforce this.
// depends on cht_pkg, cht_bucket_hash, cht_entry_ram, cht_fill_store
module chained_hash_table_engine_core
    import cht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_word_t             cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_word_t             res,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = BUCKETS * WAYS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int FILL_W = $clog2(WAYS + 1);

    ctrl_state_t         state_reg, state_next;
    cmd_word_t           cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   slot_reg, slot_next;
    logic [BKT_W-1:0]    bucket_reg, bucket_next;
    logic                pend_valid_reg, pend_valid_next;
    ent_t                pend_reg, pend_next;
    logic                res_valid_reg, res_valid_next;
    res_word_t           res_reg;
    logic [GRADE_W-1:0]  min_grade_reg;
    logic [GRADE_W-1:0]  max_grade_reg;

    logic                can_load;
    logic                res_load;
    res_word_t           res_word;

    logic                hash_start;
    logic                hash_done;
    logic [BKT_W-1:0]    hash_bucket;

    logic                fill_rd_en;
    logic [BKT_W-1:0]    fill_rd_addr;
    logic [FILL_W-1:0]   fill_rd_data;
    logic                fill_wr_en;
    logic [FILL_W-1:0]   fill_wr_data;

    logic                ent_rd_en;
    logic [ADDR_W-1:0]   ent_rd_addr;
    ent_t                ent_rd_data;
    logic                ent_wr_en;
    logic [ADDR_W-1:0]   ent_wr_addr;
    ent_t                ent_wr_data;

    logic [ADDR_W-1:0]   slot_addr;
    logic [ADDR_W-1:0]   fill_addr;
    logic                grade_in_range;
    logic                key_hit;

    // bucket hash pipeline
    cht_bucket_hash #(
        .BUCKETS (BUCKETS),
        .BKT_W   (BKT_W)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (cmd.student_key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    // fill counts
    cht_fill_store #(
        .BUCKETS (BUCKETS),
        .BKT_W   (BKT_W),
        .FILL_W  (FILL_W)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (fill_rd_en),
        .rd_addr (fill_rd_addr),
        .rd_fill (fill_rd_data),
        .wr_en   (fill_wr_en),
        .wr_addr (bucket_reg),
        .wr_fill (fill_wr_data)
    );

    // entries
    cht_entry_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ent (
        .clk     (clk),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data)
    );

    // addressing and compares
    assign slot_addr      = base_reg + ADDR_W'(slot_reg);
    assign fill_addr      = base_reg + ADDR_W'(fill_reg);
    assign key_hit        = (ent_rd_data.key == cmd_reg.student_key);
    assign grade_in_range = (ent_rd_data.grade >= min_grade_reg) &&
                            (ent_rd_data.grade <= max_grade_reg);
    assign can_load       = !res_valid_reg || res_ready;

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        base_next       = base_reg;
        fill_next       = fill_reg;
        slot_next       = slot_reg;
        bucket_next     = bucket_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cmd_ready       = 1'b0;
        hash_start      = 1'b0;
        fill_rd_en      = 1'b0;
        fill_rd_addr    = bucket_reg;
        fill_wr_en      = 1'b0;
        fill_wr_data    = fill_reg;
        ent_rd_en       = 1'b0;
        ent_rd_addr     = slot_addr;
        ent_wr_en       = 1'b0;
        ent_wr_addr     = slot_addr;
        ent_wr_data     = ent_rd_data;
        res_load        = 1'b0;
        res_word.status       = RS_NONE;
        res_word.result_key   = cmd_reg.student_key;
        res_word.result_grade = '0;
        res_word.last_result  = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    if (cmd.action == ACT_SCAN)
                    begin
                        bucket_next     = '0;
                        base_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN_FILL;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    fill_rd_en   = 1'b1;
                    fill_rd_addr = hash_bucket;
                    bucket_next  = hash_bucket;
                    base_next    = ADDR_W'(int'(hash_bucket) * WAYS);
                    state_next   = S_FILL_WAIT;
                end
            end

            S_FILL_WAIT:
            begin
                fill_next  = fill_rd_data;
                slot_next  = '0;
                state_next = S_WALK_RD;
            end

            // walk the bucket one slot at a time
            S_WALK_RD:
            begin
                if (slot_reg < fill_reg)
                begin
                    ent_rd_en  = 1'b1;
                    state_next = S_WALK_CMP;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end

            S_WALK_CMP:
            begin
                if (key_hit)
                begin
                    state_next = S_HIT;
                end
                else
                begin
                    slot_next  = slot_reg + FILL_W'(1);
                    state_next = S_WALK_RD;
                end
            end

            // key present at slot_reg; remove loops back here per moved entry
            S_HIT:
            begin
                case (cmd_reg.action)
                    ACT_INSERT:
                    begin
                        if (can_load)
                        begin
                            ent_wr_en         = 1'b1;
                            ent_wr_data.key   = cmd_reg.student_key;
                            ent_wr_data.grade = cmd_reg.grade_value;
                            res_load          = 1'b1;
                            res_word.status   = RS_UPDATED;
                            state_next        = S_IDLE;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if ((slot_reg + FILL_W'(1)) < fill_reg)
                        begin
                            ent_rd_en   = 1'b1;
                            ent_rd_addr = slot_addr + ADDR_W'(1);
                            state_next  = S_SHIFT_WR;
                        end
                        else if (can_load)
                        begin
                            fill_wr_en      = 1'b1;
                            fill_wr_data    = fill_reg - FILL_W'(1);
                            res_load        = 1'b1;
                            res_word.status = RS_REMOVED;
                            state_next      = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (can_load)
                        begin
                            res_load              = 1'b1;
                            res_word.status       = RS_FOUND;
                            res_word.result_grade = ent_rd_data.grade;
                            state_next            = S_IDLE;
                        end
                    end
                endcase
            end

            // close the gap: write the next entry one slot up
            S_SHIFT_WR:
            begin
                ent_wr_en  = 1'b1;
                slot_next  = slot_reg + FILL_W'(1);
                state_next = S_HIT;
            end

            // key absent from its bucket
            S_MISS:
            begin
                if (can_load)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (cmd_reg.action != ACT_INSERT)
                    begin
                        res_word.status = RS_MISSING;
                    end
                    else if (fill_reg >= FILL_W'(WAYS))
                    begin
                        res_word.status = RS_FULL;
                    end
                    else
                    begin
                        ent_wr_en         = 1'b1;
                        ent_wr_addr       = fill_addr;
                        ent_wr_data.key   = cmd_reg.student_key;
                        ent_wr_data.grade = cmd_reg.grade_value;
                        fill_wr_en        = 1'b1;
                        fill_wr_data      = fill_reg + FILL_W'(1);
                        res_word.status   = RS_INSERTED;
                    end
                end
            end

            // range scan over buckets, then slots
            S_SCAN_FILL:
            begin
                fill_rd_en = 1'b1;
                state_next = S_SCAN_FWAIT;
            end

            S_SCAN_FWAIT:
            begin
                fill_next  = fill_rd_data;
                slot_next  = '0;
                state_next = S_SCAN_RD;
            end

            S_SCAN_RD:
            begin
                if (slot_reg < fill_reg)
                begin
                    ent_rd_en  = 1'b1;
                    state_next = S_SCAN_CMP;
                end
                else if (bucket_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    bucket_next = bucket_reg + BKT_W'(1);
                    base_next   = base_reg + ADDR_W'(WAYS);
                    state_next  = S_SCAN_FILL;
                end
            end

            // one match is held back so the final one can carry the last flag
            S_SCAN_CMP:
            begin
                if (!grade_in_range)
                begin
                    slot_next  = slot_reg + FILL_W'(1);
                    state_next = S_SCAN_RD;
                end
                else if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = ent_rd_data;
                    slot_next       = slot_reg + FILL_W'(1);
                    state_next      = S_SCAN_RD;
                end
                else if (can_load)
                begin
                    res_load              = 1'b1;
                    res_word.status       = RS_MATCH;
                    res_word.result_key   = pend_reg.key;
                    res_word.result_grade = pend_reg.grade;
                    res_word.last_result  = 1'b0;
                    pend_next             = ent_rd_data;
                    slot_next             = slot_reg + FILL_W'(1);
                    state_next            = S_SCAN_RD;
                end
            end

            S_SCAN_END:
            begin
                if (can_load)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (pend_valid_reg)
                    begin
                        res_word.status       = RS_MATCH;
                        res_word.result_key   = pend_reg.key;
                        res_word.result_grade = pend_reg.grade;
                    end
                    else
                    begin
                        res_word.status     = RS_NONE;
                        res_word.result_key = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word register
    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            min_grade_reg  <= MIN_GRADE_RST;
            max_grade_reg  <= MAX_GRADE_RST;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_MIN_GRADE: min_grade_reg <= GRADE_W'(cfg_data);
                    CFG_MAX_GRADE: max_grade_reg <= GRADE_W'(cfg_data);
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        base_reg   <= base_next;
        fill_reg   <= fill_next;
        slot_reg   <= slot_next;
        bucket_reg <= bucket_next;
        pend_reg   <= pend_next;
        if (res_load)
        begin
            res_reg <= res_word;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a bucket never records more entries than it has slots
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_wr_en |-> (fill_wr_data <= FILL_W'(WAYS)))
        else $error("fill count beyond bucket size");

    // the hash answers only while the engine waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH))
        else $error("bucket hash result with no command waiting");

    // a compare only follows a read of a slot below the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_CMP) |-> (slot_reg < fill_reg))
        else $error("key compare beyond bucket fill");

    // the final word of a command returns the engine to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_word.last_result) |=> (state_reg == S_IDLE))
        else $error("last word issued while command still busy");

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for chained_hash_table_engine_core: random and directed command words
// are checked against an in-bench model of the bucketed table and the grade window
// depends on cht_pkg and the engine rtl
module tb_top
    import cht_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS     = BUCKETS_DEF;
    localparam int WAYS        = WAYS_DEF;
    localparam int SLOTS       = BUCKETS * WAYS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 28;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    cmd_word_t             cmd = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_word_t             res;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_GRADE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // table model: keys and grades per slot, fill per bucket, grade window
    logic [KEY_W-1:0]   table_keys   [SLOTS];
    logic [GRADE_W-1:0] table_grades [SLOTS];
    int                 bucket_count [BUCKETS];
    logic [GRADE_W-1:0] win_lo = MIN_GRADE_RST;
    logic [GRADE_W-1:0] win_hi = MAX_GRADE_RST;

    cmd_word_t        pending_cmds [$];
    res_word_t        expected_results [$];
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] crowd [5];
    res_word_t        want;

    logic cmd_taken = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    bit   hold_req = 1'b0;
    bit   idling_on = 1'b1;
    int   mismatches = 0;

    chained_hash_table_engine_core #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock, 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // byte sum of the key, modulo the bucket count
    function automatic int bucket_index(logic [KEY_W-1:0] k);
        int sum;
        sum = 0;
        for (int i = 0; i < 8; i++)
            sum += int'(k[8*i +: 8]);
        return sum % BUCKETS;
    endfunction

    function automatic cmd_word_t make_cmd(action_t a, logic [KEY_W-1:0] k,
                                           logic [GRADE_W-1:0] g);
        cmd_word_t c;
        c.action      = a;
        c.student_key = k;
        c.grade_value = g;
        return c;
    endfunction

    // append one word to the driver's queue
    function automatic void queue_cmd(cmd_word_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    // append one key to the pool of keys used by random words
    function automatic void add_key(logic [KEY_W-1:0] k);
        key_pool = {key_pool, k};
    endfunction

    // text id packed first character in the low byte
    function automatic logic [KEY_W-1:0] ascii_key(string s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            k[8*i +: 8] = s[i];
        return k;
    endfunction

    // random key steered into bucket b through its low byte
    function automatic logic [KEY_W-1:0] key_in_bucket(int b);
        logic [KEY_W-1:0] k;
        int sum;
        int r;
        k = {$urandom, $urandom};
        sum = 0;
        for (int i = 1; i < 8; i++)
            sum += int'(k[8*i +: 8]);
        r = (b - sum % BUCKETS + BUCKETS) % BUCKETS;
        k[7:0] = 8'(r + BUCKETS * $urandom_range(0, (255 - r) / BUCKETS));
        return k;
    endfunction

    // work out the result words of one accepted command and update the table
    function automatic void apply_command(cmd_word_t c);
        int b;
        int n;
        int slot;
        res_word_t r;
        res_word_t hits [$];
        b = bucket_index(c.student_key);
        n = bucket_count[b];
        slot = -1;
        for (int j = 0; j < n; j++)
            if (slot < 0 && table_keys[b*WAYS + j] == c.student_key)
                slot = j;
        r.status       = RS_NONE;
        r.result_key   = c.student_key;
        r.result_grade = '0;
        r.last_result  = 1'b1;
        case (c.action)
            ACT_INSERT:
            begin
                if (slot >= 0)
                begin
                    table_grades[b*WAYS + slot] = c.grade_value;
                    r.status = RS_UPDATED;
                end
                else if (n >= WAYS)
                    r.status = RS_FULL;
                else
                begin
                    table_keys[b*WAYS + n]   = c.student_key;
                    table_grades[b*WAYS + n] = c.grade_value;
                    bucket_count[b]++;
                    r.status = RS_INSERTED;
                end
                expected_results = {expected_results, r};
            end
            ACT_REMOVE:
            begin
                if (slot < 0)
                    r.status = RS_MISSING;
                else
                begin
                    // close the gap behind the removed entry
                    for (int j = slot; j + 1 < n; j++)
                    begin
                        table_keys[b*WAYS + j]   = table_keys[b*WAYS + j + 1];
                        table_grades[b*WAYS + j] = table_grades[b*WAYS + j + 1];
                    end
                    bucket_count[b]--;
                    r.status = RS_REMOVED;
                end
                expected_results = {expected_results, r};
            end
            ACT_LOOKUP:
            begin
                if (slot < 0)
                    r.status = RS_MISSING;
                else
                begin
                    r.status       = RS_FOUND;
                    r.result_grade = table_grades[b*WAYS + slot];
                end
                expected_results = {expected_results, r};
            end
            default:
            begin
                // grade window scan in bucket then slot order
                for (int i = 0; i < BUCKETS; i++)
                    for (int j = 0; j < bucket_count[i]; j++)
                        if (table_grades[i*WAYS + j] >= win_lo &&
                            table_grades[i*WAYS + j] <= win_hi)
                        begin
                            r.status       = RS_MATCH;
                            r.result_key   = table_keys[i*WAYS + j];
                            r.result_grade = table_grades[i*WAYS + j];
                            r.last_result  = 1'b0;
                            hits = {hits, r};
                        end
                if (hits.size() == 0)
                begin
                    r.status       = RS_NONE;
                    r.result_key   = '0;
                    r.result_grade = '0;
                    r.last_result  = 1'b1;
                    hits = {hits, r};
                end
                else
                    hits[hits.size() - 1].last_result = 1'b1;
                expected_results = {expected_results, hits};
            end
        endcase
    endfunction

    // mostly pool keys so that entries get hit, some fresh random keys as noise
    function automatic cmd_word_t random_cmd();
        int pick;
        action_t a;
        logic [KEY_W-1:0] k;
        logic [GRADE_W-1:0] g;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            a = ACT_INSERT;
        else if (pick < 60)
            a = ACT_REMOVE;
        else if (pick < 88)
            a = ACT_LOOKUP;
        else
            a = ACT_SCAN;
        if ($urandom_range(0, 4) == 0)
            k = {$urandom, $urandom};
        else
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        case ($urandom_range(0, 5))
            0: g = '0;
            1: g = '1;
            default: g = GRADE_W'($urandom_range(0, 255));
        endcase
        return make_cmd(a, k, g);
    endfunction

    // wait until no word is queued, offered or outstanding
    task automatic settle_idle();
        @(posedge clk);
        #1;
        while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    // new grade window written while idle, then a batch of random words
    task automatic run_phase(logic [GRADE_W-1:0] lo, logic [GRADE_W-1:0] hi,
                             bit with_hold, bit with_idle);
        settle_idle();
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MIN_GRADE;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_MAX_GRADE;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        #1;
        idling_on = with_idle;
        hold_req  = with_hold;
        repeat (PHASE_WORDS) queue_cmd(random_cmd());
    endtask

    // command driver, fed from the pending queue
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() == 0)
                cmd_valid <= 1'b0;
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 18);
                cmd_valid <= 1'b0;
            end
            else
            begin
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            res_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // monitor: register writes, accepted commands and result words
    always @(posedge clk)
    begin
        cmd_taken <= rst_n && cmd_valid && cmd_ready;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_MIN_GRADE)
                    win_lo = cfg_data;
                else if (cfg_index == CFG_MAX_GRADE)
                    win_hi = cfg_data;
            end
            if (cmd_valid && cmd_ready)
                apply_command(cmd);
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, res);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status !== res.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, res.status);
                    end
                    if (want.result_key !== res.result_key)
                    begin
                        mismatches++;
                        $display("%0t: result_key expected %h, got %h",
                                 $time, want.result_key, res.result_key);
                    end
                    if (want.result_grade !== res.result_grade)
                    begin
                        mismatches++;
                        $display("%0t: result_grade expected %0d, got %0d",
                                 $time, want.result_grade, res.result_grade);
                    end
                    if (want.last_result !== res.last_result)
                    begin
                        mismatches++;
                        $display("%0t: last_result expected %0b, got %0b",
                                 $time, want.last_result, res.last_result);
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("chained_hash_table_engine_core verification failed");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        foreach (bucket_count[i])
            bucket_count[i] = 0;

        // key pool: extremes, text ids, a crowded bucket and a random spread
        for (int i = 0; i < 5; i++)
            crowd[i] = key_in_bucket(7);
        add_key('0);
        add_key('1);
        add_key(ascii_key("STU42"));
        add_key(ascii_key("ID000001"));
        add_key(ascii_key("Z"));
        foreach (crowd[i])
            add_key(crowd[i]);
        add_key(key_in_bucket(7));
        add_key(key_in_bucket(0));
        for (int i = 0; i < 12; i++)
            add_key(key_in_bucket($urandom_range(0, BUCKETS - 1)));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        #1;

        // directed words under the reset grade window
        queue_cmd(make_cmd(ACT_SCAN, {$urandom, $urandom}, 8'hA5));
        queue_cmd(make_cmd(ACT_LOOKUP, '0, '0));
        queue_cmd(make_cmd(ACT_INSERT, '0, '0));
        queue_cmd(make_cmd(ACT_INSERT, '0, 8'd85));
        queue_cmd(make_cmd(ACT_LOOKUP, '0, '1));
        queue_cmd(make_cmd(ACT_INSERT, '1, '1));
        queue_cmd(make_cmd(ACT_LOOKUP, '1, '0));
        // fill one bucket past its ways, grades either side of the window edges
        queue_cmd(make_cmd(ACT_INSERT, crowd[0], 8'd80));
        queue_cmd(make_cmd(ACT_INSERT, crowd[1], 8'd90));
        queue_cmd(make_cmd(ACT_INSERT, crowd[2], 8'd79));
        queue_cmd(make_cmd(ACT_INSERT, crowd[3], 8'd91));
        queue_cmd(make_cmd(ACT_INSERT, crowd[4], 8'd255));
        queue_cmd(make_cmd(ACT_SCAN, '0, '0));
        // remove from the middle, then probe the closed gap
        queue_cmd(make_cmd(ACT_REMOVE, crowd[1], '1));
        queue_cmd(make_cmd(ACT_LOOKUP, crowd[2], '0));
        queue_cmd(make_cmd(ACT_REMOVE, crowd[1], '0));
        queue_cmd(make_cmd(ACT_LOOKUP, crowd[1], '0));
        queue_cmd(make_cmd(ACT_INSERT, crowd[4], 8'd86));
        queue_cmd(make_cmd(ACT_INSERT, ascii_key("STU42"), 8'd88));
        queue_cmd(make_cmd(ACT_SCAN, '1, '1));

        // random phases over several grade windows
        run_phase(8'd0,   8'd255, 1'b0, 1'b1);
        run_phase(8'd255, 8'd255, 1'b1, 1'b1);
        run_phase(8'd0,   8'd0,   1'b0, 1'b0);
        run_phase(8'd200, 8'd100, 1'b0, 1'b1);
        run_phase(8'd40,  8'd160, 1'b0, 1'b1);
        run_phase(8'd80,  8'd90,  1'b0, 1'b0);

        // drain, then let the engine run out
        settle_idle();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("chained_hash_table_engine_core verification clean");
        else
            $display("chained_hash_table_engine_core verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cht_pkg.sv
rtl/cht_bucket_hash.sv
rtl/cht_entry_ram.sv
rtl/cht_fill_store.sv
rtl/chained_hash_table_engine_core.sv
tb/sv/tb_top.sv
